### design/spd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_pkg: shared types and constants of the sensor packet deframer
// Item and result codes, frame phases, register indexes and the structs
// that pass between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package spd_pkg;

  // Input item kinds
  localparam logic ITEM_BYTE = 1'b0;
  localparam logic ITEM_TICK = 1'b1;

  // Result kinds
  localparam logic [1:0] RES_PAYLOAD = 2'd0;
  localparam logic [1:0] RES_DONE    = 2'd1;
  localparam logic [1:0] RES_TIMEOUT = 2'd2;
  localparam logic [1:0] RES_LEN_ERR = 2'd3;

  // Frame phases
  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_TRAILER = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_START_CODE  = 3'd0;
  localparam logic [2:0] REG_HUNT_TO     = 3'd1;
  localparam logic [2:0] REG_HEADER_TO   = 3'd2;
  localparam logic [2:0] REG_BYTE_TO     = 3'd3;
  localparam logic [2:0] REG_TRAILER_TO  = 3'd4;

  // Register reset values
  localparam logic [15:0] START_CODE_RST = 16'hEF01;
  localparam logic [15:0] HUNT_TO_RST    = 16'd2000;
  localparam logic [15:0] HEADER_TO_RST  = 16'd7000;
  localparam logic [15:0] BYTE_TO_RST    = 16'd1000;
  localparam logic [15:0] TRAILER_TO_RST = 16'd2000;

  // Header layout
  localparam logic [2:0] HDR_KIND_POS  = 3'd4;
  localparam logic [2:0] HDR_LEN_H_POS = 3'd5;
  localparam logic [2:0] HDR_LAST_POS  = 3'd6;
  localparam logic [15:0] LEN_OVERHEAD = 16'd2;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [15:0] start_code;
    logic [15:0] hunt_to;
    logic [15:0] header_to;
    logic [15:0] byte_to;
    logic [15:0] trailer_to;
  } cfg_t;

  // Classified input beat
  typedef struct packed {
    logic       is_tick;
    logic       code_lo_hit;
    logic [7:0] byte_val;
  } cmd_t;

  // Result beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [31:0] frame_address;
    logic [7:0]  packet_kind;
    logic [15:0] packet_length;
    logic [15:0] received_sum;
    logic        sum_matches;
  } res_t;

endpackage
`default_nettype wire

### design/spd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_front: input front end
// Accepts input beats, sorts them into ticks and bytes and flags bytes that
// match the low half of the start code, then hands them to the queue.
// ----------------------------------------------------------------------------
module spd_front import spd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_item_kind,
  input  wire logic [7:0] in_byte_value,
  input  wire logic [7:0] start_code_lo,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_cmd
);

  // Registered stall flag so that the upstream side sees a clean signal.
  logic stall_r;
  logic stall_nxt;

  assign in_stall = stall_r;
  assign q_push   = in_valid && !stall_r;

  // Stall whenever the queue reports full for the next cycle.
  assign stall_nxt = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stall_r <= 1'b1;
    end else begin
      stall_r <= stall_nxt;
    end
  end

  // Classify the beat.
  always_comb begin
    q_cmd.is_tick     = (in_item_kind == ITEM_TICK);
    q_cmd.byte_val    = in_byte_value;
    q_cmd.code_lo_hit = (in_byte_value == start_code_lo);
  end

endmodule
`default_nettype wire

### design/spd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_queue: two-entry queue between front and back end
// Decouples input acceptance from result back-pressure. Reports full
// for the next cycle so that the front end can register its stall.
// ----------------------------------------------------------------------------
module spd_queue import spd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output logic      q_valid,
  output cmd_t      q_cmd,
  output logic      full_next
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign q_valid = (count_r != 2'd0);
  assign q_cmd   = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  // Full flag for the next cycle: raised once both slots will be taken, so
  // a beat pushed while the registered stall is still low finds a free slot.
  assign full_next = (count_nxt == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

### design/spd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_back: deframer back end
// Runs the hunt, header, payload and trailer phases with the tick timer,
// keeps the checksum and drives the registered result beat.
// ----------------------------------------------------------------------------
module spd_back import spd_pkg::*; #(
  parameter int MAX_PAYLOAD = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  cfg_t      cfg,
  input  wire logic q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output res_t      out_res
);

  localparam logic [16:0] LEN_MAX = 17'(MAX_PAYLOAD + 2);

  // Control state
  logic [1:0]  phase_r, phase_nxt;
  logic        prev_valid_r, prev_valid_nxt;
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [15:0] tick_cnt_r, tick_cnt_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Frame payload state
  logic [7:0]  prev_byte_r, prev_byte_nxt;
  logic [8:0]  pay_cnt_r, pay_cnt_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  csum_hi_r, csum_hi_nxt;

  res_t        res_r, res_nxt;
  logic        emit;

  logic        slot_free;
  logic        go;
  logic [15:0] limit;
  logic [15:0] len_new;
  logic [8:0]  pay_cnt_inc;
  logic [15:0] rs;
  logic [7:0]  b;

  assign slot_free = !out_valid_r || !out_stall;
  assign go        = q_valid && slot_free;
  assign q_pop     = go;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  assign b           = q_cmd.byte_val;
  assign len_new     = {len_r[15:8], b};
  assign pay_cnt_inc = pay_cnt_r + 9'd1;
  assign rs          = {csum_hi_r, b};

  // Timeout limit of the current phase.
  always_comb begin
    unique case (phase_r)
      PH_HUNT:    limit = cfg.hunt_to;
      PH_HEADER:  limit = cfg.header_to;
      PH_PAYLOAD: limit = cfg.byte_to;
      default:    limit = cfg.trailer_to;
    endcase
  end

  // Per-beat state update.
  always_comb begin
    phase_nxt      = phase_r;
    prev_valid_nxt = prev_valid_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    tick_cnt_nxt   = tick_cnt_r;
    prev_byte_nxt  = prev_byte_r;
    pay_cnt_nxt    = pay_cnt_r;
    addr_nxt       = addr_r;
    kind_nxt       = kind_r;
    len_nxt        = len_r;
    sum_nxt        = sum_r;
    csum_hi_nxt    = csum_hi_r;
    res_nxt        = '0;
    emit           = 1'b0;

    if (go) begin
      if (q_cmd.is_tick) begin
        // Millisecond tick: time out or count.
        if (tick_cnt_r >= limit) begin
          if (phase_r != PH_HUNT) begin
            prev_valid_nxt = 1'b0;
          end
          phase_nxt    = PH_HUNT;
          tick_cnt_nxt = '0;
          res_nxt.kind = RES_TIMEOUT;
          emit         = 1'b1;
        end else begin
          tick_cnt_nxt = tick_cnt_r + 16'd1;
        end
      end else begin
        unique case (phase_r)
          PH_HUNT: begin
            // Two-byte sliding window over the stream.
            if (prev_valid_r && (prev_byte_r == cfg.start_code[15:8]) &&
                q_cmd.code_lo_hit) begin
              phase_nxt      = PH_HEADER;
              hdr_cnt_nxt    = '0;
              addr_nxt       = '0;
              prev_valid_nxt = 1'b0;
            end else begin
              prev_byte_nxt  = b;
              prev_valid_nxt = 1'b1;
            end
            tick_cnt_nxt = '0;
          end
          PH_HEADER: begin
            // Address, type and length bytes, big-endian.
            hdr_cnt_nxt = hdr_cnt_r + 3'd1;
            if (hdr_cnt_r < HDR_KIND_POS) begin
              addr_nxt = {addr_r[23:0], b};
            end else if (hdr_cnt_r == HDR_KIND_POS) begin
              kind_nxt = b;
            end else if (hdr_cnt_r == HDR_LEN_H_POS) begin
              len_nxt = {b, 8'h00};
            end else begin
              len_nxt = len_new;
            end
            if (hdr_cnt_r == HDR_LAST_POS) begin
              hdr_cnt_nxt  = '0;
              tick_cnt_nxt = '0;
              if ((len_new < LEN_OVERHEAD) || ({1'b0, len_new} > LEN_MAX)) begin
                phase_nxt             = PH_HUNT;
                prev_valid_nxt        = 1'b0;
                res_nxt.kind          = RES_LEN_ERR;
                res_nxt.frame_address = addr_r;
                res_nxt.packet_kind   = kind_r;
                res_nxt.packet_length = len_new;
                emit                  = 1'b1;
              end else begin
                sum_nxt     = {8'h00, len_new[15:8]} + {8'h00, b} + {8'h00, kind_r};
                pay_cnt_nxt = '0;
                phase_nxt   = (len_new == LEN_OVERHEAD) ? PH_TRAILER : PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            // Stream each payload byte out as it arrives.
            sum_nxt      = sum_r + {8'h00, b};
            pay_cnt_nxt  = pay_cnt_inc;
            tick_cnt_nxt = '0;
            if ({7'h00, pay_cnt_inc} >= (len_r - LEN_OVERHEAD)) begin
              phase_nxt   = PH_TRAILER;
              hdr_cnt_nxt = '0;
            end
            res_nxt.kind          = RES_PAYLOAD;
            res_nxt.payload_byte  = b;
            res_nxt.payload_index = pay_cnt_r[7:0];
            res_nxt.frame_address = addr_r;
            res_nxt.packet_kind   = kind_r;
            res_nxt.packet_length = len_r;
            emit                  = 1'b1;
          end
          default: begin
            // Checksum bytes, high byte first.
            if (hdr_cnt_r == 3'd0) begin
              csum_hi_nxt = b;
              hdr_cnt_nxt = 3'd1;
            end else begin
              phase_nxt             = PH_HUNT;
              hdr_cnt_nxt           = '0;
              tick_cnt_nxt          = '0;
              prev_valid_nxt        = 1'b0;
              res_nxt.kind          = RES_DONE;
              res_nxt.frame_address = addr_r;
              res_nxt.packet_kind   = kind_r;
              res_nxt.packet_length = len_r;
              res_nxt.received_sum  = rs;
              res_nxt.sum_matches   = (rs == sum_r);
              emit                  = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Output beat valid: load on a new result, clear when taken.
  always_comb begin
    if (go) begin
      out_valid_nxt = emit;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      prev_valid_r <= 1'b0;
      hdr_cnt_r    <= '0;
      tick_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
      prev_byte_r  <= '0;
      pay_cnt_r    <= '0;
      addr_r       <= '0;
      kind_r       <= '0;
      len_r        <= '0;
      sum_r        <= '0;
      csum_hi_r    <= '0;
    end else begin
      phase_r      <= phase_nxt;
      prev_valid_r <= prev_valid_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      tick_cnt_r   <= tick_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      prev_byte_r  <= prev_byte_nxt;
      pay_cnt_r    <= pay_cnt_nxt;
      addr_r       <= addr_nxt;
      kind_r       <= kind_nxt;
      len_r        <= len_nxt;
      sum_r        <= sum_nxt;
      csum_hi_r    <= csum_hi_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (go && emit) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire

### design/sensor_packet_deframer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_packet_deframer_unit: start-code packet deframer with tick timeouts
// Hunts a two-byte start code, reads the header, streams the payload and
// reports the frame end with its checksum, timeouts and length errors.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  item_kind, byte_value
//   out_     output     out_valid/out_stall result kind, payload and header
//   cfg_     input      cfg_valid/cfg_ready register index and 16-bit data
//
// One beat a cycle is taken while no result is stalled. An accepted beat
// is written to the queue and handled by the back end once it heads the
// queue and the result slot is free; its result, if any, is registered.
// The input stall is registered and rises once both queue slots will be
// taken; a stalled result holds up the back end, so the queue then fills.
// Reset is synchronous; it restores the register defaults and hunting.
// ----------------------------------------------------------------------------
module sensor_packet_deframer_unit import spd_pkg::*; #(
  parameter int MAX_PAYLOAD = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_item_kind,
  input  wire logic [7:0]  in_byte_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [7:0]       out_payload_byte,
  output logic [7:0]       out_payload_index,
  output logic [31:0]      out_frame_address,
  output logic [7:0]       out_packet_kind,
  output logic [15:0]      out_packet_length,
  output logic [15:0]      out_received_sum,
  output logic             out_sum_matches,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic q_full;
  logic q_push;
  cmd_t push_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd;
  res_t res;

  // Configuration registers, always ready.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_CODE: cfg_nxt.start_code = cfg_data;
        REG_HUNT_TO:    cfg_nxt.hunt_to    = cfg_data;
        REG_HEADER_TO:  cfg_nxt.header_to  = cfg_data;
        REG_BYTE_TO:    cfg_nxt.byte_to    = cfg_data;
        REG_TRAILER_TO: cfg_nxt.trailer_to = cfg_data;
        default:        cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code <= START_CODE_RST;
      cfg_r.hunt_to    <= HUNT_TO_RST;
      cfg_r.header_to  <= HEADER_TO_RST;
      cfg_r.byte_to    <= BYTE_TO_RST;
      cfg_r.trailer_to <= TRAILER_TO_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: accept and classify.
  spd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item_kind (in_item_kind),
    .in_byte_value(in_byte_value),
    .start_code_lo(cfg_r.start_code[7:0]),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  // Queue between the two halves.
  spd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .full_next(q_full)
  );

  // Back end: deframing and results.
  spd_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (res)
  );

  // Result fields.
  assign out_result_kind   = res.kind;
  assign out_payload_byte  = res.payload_byte;
  assign out_payload_index = res.payload_index;
  assign out_frame_address = res.frame_address;
  assign out_packet_kind   = res.packet_kind;
  assign out_packet_length = res.packet_length;
  assign out_received_sum  = res.received_sum;
  assign out_sum_matches   = res.sum_matches;

endmodule
`default_nettype wire
